@@ rtl/assert_macros.svh @@
// assertion macros for the route lookup rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lpr_pkg.sv @@
// shared types, constants and functions for the route lookup block
package lpr_pkg;

    localparam int unsigned TableDepth = 64;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_FILTERED = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic [31:0] FLAG_UP     = 32'h0000_0001;
    localparam logic [31:0] FLAG_STATIC = 32'h0000_0800;
    localparam logic [31:0] FLAG_CLONED = 32'h0002_0000;
    localparam logic [31:0] FLAG_SCOPED = 32'h0100_0000;

    // stored route: address, mask and interface
    localparam int unsigned EntryWidth = 128 + 128 + 16;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic rd_start;   // start a read at the walk pointer
        logic ptr_clear;  // walk pointer to 0
        logic ptr_inc;    // walk pointer up
        logic ptr_dec;    // walk pointer down
        logic ptr_to_end; // walk pointer to table count
        logic wr_shift;   // write previous entry one place up
        logic wr_new;     // write new entry at walk pointer
        logic cnt_inc;    // table count up
        logic cnt_clear;  // both counts to 0
        logic hit_set;    // latch the matched interface
    } lpr_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       filtered;
        logic       full;
        logic       ptr_at_end;  // walk pointer equals table count
        logic       ptr_zero;
        logic       entry_hit;   // read entry matches destination
        logic       entry_less;  // new mask greater than read mask
    } lpr_stat_t;

    // true when a route matches the destination under byte-wise mask rules
    function automatic logic route_match(input logic [127:0] a, input logic [127:0] m,
                                         input logic [127:0] d);
        logic ok;
        logic stop;
        ok = 1'b1;
        stop = 1'b0;
        for (int i = 0; i < 16; i++) begin
            if (!stop) begin
                if (m[127-8*i -: 8] == 8'h00) begin
                    stop = 1'b1;
                end else if ((d[127-8*i -: 8] & m[127-8*i -: 8]) != a[127-8*i -: 8]) begin
                    ok = 1'b0;
                    stop = 1'b1;
                end
            end
        end
        return ok;
    endfunction

endpackage

@@ rtl/longest_prefix_route_lookup_top.sv @@
// Lookup: walks the table from entry 0 until an entry matches or the table ends.
// Insert: position search, then each entry to be moved is read and written one place up,
// from the end of the table down. Clear, filtered and full inserts go straight to the result.
// One beat at a time; next beat is taken once the result beat has been accepted.
// Reset (rst_n, async active low) empties both tables; entry contents stay unknown.
module longest_prefix_route_lookup_top #(
    parameter int unsigned TABLE_DEPTH = lpr_pkg::TableDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic        family_v6,
    input  logic [63:0] addr_hi,
    input  logic [63:0] addr_lo,
    input  logic [63:0] mask_hi,
    input  logic [63:0] mask_lo,
    input  logic [15:0] port_index,
    input  logic [31:0] route_flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] match_index,
    output logic [1:0]  status
);

`include "assert_macros.svh"

    lpr_pkg::lpr_cmd_t  cmd;
    lpr_pkg::lpr_stat_t stat;
    logic [15:0]        hit_port;

    lpr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .status(status),
        .cmd(cmd), .stat(stat)
    );

    lpr_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .kind(kind), .family_v6(family_v6),
        .addr_hi(addr_hi), .addr_lo(addr_lo),
        .mask_hi(mask_hi), .mask_lo(mask_lo),
        .port_index(port_index), .route_flags(route_flags),
        .hit_port(hit_port)
    );

    // interface is zero unless a lookup hit
    assign match_index = found ? hit_port : 16'd0;

    `ASSERT_ALWAYS(a_no_overlap, clk, rst_n, !(in_ready && out_valid), "ready while result pending")
    `ASSERT_ALWAYS(a_found_ok, clk, rst_n, !(out_valid && found) || (status == lpr_pkg::STATUS_DONE), "hit with bad status")
    `ASSERT_NEXT(a_beat_held, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")

endmodule

@@ rtl/lpr_ram.sv @@
// generic single port write, single port registered read ram
module lpr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/lpr_datapath.sv @@
// datapath: input capture, table memories, walk pointer and compare
module lpr_datapath #(
    parameter int unsigned TABLE_DEPTH = lpr_pkg::TableDepth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lpr_pkg::lpr_cmd_t   cmd,
    output lpr_pkg::lpr_stat_t stat,
    input  logic [1:0]          kind,
    input  logic                family_v6,
    input  logic [63:0]         addr_hi,
    input  logic [63:0]         addr_lo,
    input  logic [63:0]         mask_hi,
    input  logic [63:0]         mask_lo,
    input  logic [15:0]         port_index,
    input  logic [31:0]         route_flags,
    output logic [15:0]         hit_port
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned EW = lpr_pkg::EntryWidth;

    logic [1:0]   kind_reg;
    logic         v6_reg;
    logic [127:0] addr_reg;
    logic [127:0] mask_reg;
    logic [15:0]  port_reg;
    logic [31:0]  flags_reg;
    logic [CW-1:0] v4_cnt_reg, v6_cnt_reg, cnt;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [15:0]  hit_reg;
    logic [EW-1:0] rd4, rd6, rd, wdata;
    logic [AW-1:0] raddr, waddr;
    logic          we4, we6;
    logic [127:0]  e_addr, e_mask;

    // capture the beat; ipv4 keeps only the top word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            v6_reg    <= family_v6;
            addr_reg  <= family_v6 ? {addr_hi, addr_lo} : {addr_hi[63:32], 96'd0};
            mask_reg  <= family_v6 ? {mask_hi, mask_lo} : {mask_hi[63:32], 96'd0};
            port_reg  <= port_index;
            flags_reg <= route_flags;
        end
        if (cmd.hit_set)
        begin
            hit_reg <= rd[15:0];
        end
    end

    // walk pointer
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.ptr_clear)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_to_end)
        begin
            ptr_next = cnt;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - CW'(1);
        end
    end

    // pointer and table counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            v4_cnt_reg <= '0;
            v6_cnt_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.cnt_clear)
            begin
                v4_cnt_reg <= '0;
                v6_cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                if (v6_reg)
                begin
                    v6_cnt_reg <= v6_cnt_reg + CW'(1);
                end
                else
                begin
                    v4_cnt_reg <= v4_cnt_reg + CW'(1);
                end
            end
        end
    end

    assign cnt = v6_reg ? v6_cnt_reg : v4_cnt_reg;

    // read at the next pointer on a start, else hold the current one;
    // a shifted entry goes one place above the pointer, a new one at the next pointer
    assign raddr = cmd.rd_start ? AW'(ptr_next) : AW'(ptr_reg);
    assign waddr = cmd.wr_shift ? AW'(ptr_reg + CW'(1)) : AW'(ptr_next);
    assign wdata = cmd.wr_new ? {addr_reg, mask_reg, port_reg} : rd;
    assign we4   = (cmd.wr_shift || cmd.wr_new) && !v6_reg;
    assign we6   = (cmd.wr_shift || cmd.wr_new) && v6_reg;

    lpr_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_v4 (
        .clk(clk), .we(we4), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd4)
    );

    lpr_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_v6 (
        .clk(clk), .we(we6), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd6)
    );

    assign rd     = v6_reg ? rd6 : rd4;
    assign e_addr = rd[EW-1 -: 128];
    assign e_mask = rd[EW-129 -: 128];

    // status back to the controller
    always_comb
    begin
        stat.kind       = kind_reg;
        stat.filtered   = ((flags_reg & lpr_pkg::FLAG_UP) == '0)
                          || ((flags_reg & lpr_pkg::FLAG_STATIC) == '0)
                          || ((flags_reg & lpr_pkg::FLAG_CLONED) != '0)
                          || ((flags_reg & lpr_pkg::FLAG_SCOPED) != '0);
        stat.full       = (cnt == CW'(TABLE_DEPTH));
        stat.ptr_at_end = (ptr_reg == cnt);
        stat.ptr_zero   = (ptr_reg == '0);
        stat.entry_hit  = lpr_pkg::route_match(e_addr, e_mask, addr_reg);
        stat.entry_less = (mask_reg > e_mask);
    end

    assign hit_port = hit_reg;

endmodule

@@ rtl/lpr_ctrl.sv @@
// controller: sequences capture, table walk, insert shift and result beat
module lpr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [1:0]         status,
    output lpr_pkg::lpr_cmd_t  cmd,
    input  lpr_pkg::lpr_stat_t stat
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_LOOK   = 7'b0000100,
        S_FIND   = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic       found_reg, found_next;
    logic [1:0] status_reg, status_next;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        found_next  = found_reg;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                found_next  = 1'b0;
                status_next = lpr_pkg::STATUS_DONE;
                state_next  = S_OUT;
                if (stat.kind == lpr_pkg::KIND_CLEAR)
                begin
                    cmd.cnt_clear = 1'b1;
                end
                else if (stat.kind == lpr_pkg::KIND_LOOKUP)
                begin
                    cmd.ptr_clear = 1'b1;
                    cmd.rd_start  = 1'b1;
                    state_next    = S_LOOK;
                end
                else if (stat.kind == lpr_pkg::KIND_INSERT)
                begin
                    if (stat.filtered)
                    begin
                        status_next = lpr_pkg::STATUS_FILTERED;
                    end
                    else if (stat.full)
                    begin
                        status_next = lpr_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        cmd.ptr_clear = 1'b1;
                        cmd.rd_start  = 1'b1;
                        state_next    = S_FIND;
                    end
                end
            end
            // walk entries until one matches or the table ends
            S_LOOK:
            begin
                if (stat.ptr_at_end)
                begin
                    state_next = S_OUT;
                end
                else if (stat.entry_hit)
                begin
                    cmd.hit_set = 1'b1;
                    found_next  = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.ptr_inc  = 1'b1;
                    cmd.rd_start = 1'b1;
                end
            end
            // find the insert position, then start shifting from the end
            S_FIND:
            begin
                if (stat.ptr_at_end || stat.entry_less)
                begin
                    cmd.ptr_to_end = 1'b1;
                    state_next     = S_SHIFT;
                end
                else
                begin
                    cmd.ptr_inc  = 1'b1;
                    cmd.rd_start = 1'b1;
                end
            end
            // slot at ptr is free: at the bottom place the new entry, else read ptr-1
            S_SHIFT:
            begin
                if (stat.ptr_zero)
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.rd_start = 1'b1;
                    cmd.ptr_dec  = 1'b1;
                    state_next   = S_WRITE;
                end
            end
            // move a less specific entry up one place, else the new entry goes above it
            S_WRITE:
            begin
                if (stat.entry_less)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = S_SHIFT;
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            found_reg  <= 1'b0;
            status_reg <= lpr_pkg::STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

@@ sim/longest_prefix_route_lookup_top_tb.sv @@
// testbench for the route lookup block: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module longest_prefix_route_lookup_top_tb;

    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [31:0] FLAGS_OK    = lpr_pkg::FLAG_UP | lpr_pkg::FLAG_STATIC;
    localparam int unsigned DEPTH       = lpr_pkg::TableDepth;

    typedef struct {
        logic [1:0]  kind;
        logic        v6;
        logic [63:0] ahi;
        logic [63:0] alo;
        logic [63:0] mhi;
        logic [63:0] mlo;
        logic [15:0] port;
        logic [31:0] flags;
    } route_beat_t;

    typedef struct {
        logic        found;
        logic [15:0] idx;
        logic [1:0]  status;
    } route_res_t;

    typedef struct {
        route_beat_t beat;
        bit          typed;
        route_res_t  res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic        family_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [15:0] port_index;
    logic [31:0] route_flags;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [15:0] match_index;
    logic [1:0]  status;

    // shadow route tables
    logic [31:0]  v4_addr [DEPTH];
    logic [31:0]  v4_mask [DEPTH];
    logic [15:0]  v4_port [DEPTH];
    int unsigned  v4_count;
    logic [127:0] v6_addr [DEPTH];
    logic [127:0] v6_mask [DEPTH];
    logic [15:0]  v6_port [DEPTH];
    int unsigned  v6_count;

    route_res_t   pending_results [$];
    logic [127:0] known_dests [$];
    stim_row_t    stim_rows [$];
    int           errors;
    int           beats_sent;
    int           beats_seen;
    bit           held_off;

    longest_prefix_route_lookup_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .family_v6   (family_v6),
        .addr_hi     (addr_hi),
        .addr_lo     (addr_lo),
        .mask_hi     (mask_hi),
        .mask_lo     (mask_lo),
        .port_index  (port_index),
        .route_flags (route_flags),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .match_index (match_index),
        .status      (status)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // byte-wise masked compare, stops at first zero mask byte
    function automatic bit prefix_hit(logic [127:0] a, logic [127:0] m, logic [127:0] d,
                                      int nbytes);
        logic [7:0] mb;
        for (int i = 0; i < nbytes; i++)
        begin
            mb = m[127-8*i -: 8];
            if (mb == 8'h00)
                return 1'b1;
            if ((d[127-8*i -: 8] & mb) != a[127-8*i -: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // route table behaviour: updates the shadow tables, returns the result beat
    function automatic route_res_t route_table_step(route_beat_t b);
        route_res_t   r;
        int unsigned  pos;
        logic [31:0]  a4;
        logic [31:0]  m4;
        logic [127:0] a6;
        logic [127:0] m6;
        r = '{1'b0, 16'd0, lpr_pkg::STATUS_DONE};
        a4 = b.ahi[63:32];
        m4 = b.mhi[63:32];
        a6 = {b.ahi, b.alo};
        m6 = {b.mhi, b.mlo};
        case (b.kind)
            lpr_pkg::KIND_INSERT:
            begin
                if (!(b.flags & lpr_pkg::FLAG_UP) || !(b.flags & lpr_pkg::FLAG_STATIC) ||
                    (b.flags & lpr_pkg::FLAG_CLONED) || (b.flags & lpr_pkg::FLAG_SCOPED))
                    r.status = lpr_pkg::STATUS_FILTERED;
                else if (!b.v6)
                begin
                    if (v4_count >= DEPTH)
                        r.status = lpr_pkg::STATUS_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < v4_count && !(m4 > v4_mask[pos]))
                            pos++;
                        for (int j = v4_count; j > pos; j--)
                        begin
                            v4_addr[j] = v4_addr[j-1];
                            v4_mask[j] = v4_mask[j-1];
                            v4_port[j] = v4_port[j-1];
                        end
                        v4_addr[pos] = a4;
                        v4_mask[pos] = m4;
                        v4_port[pos] = b.port;
                        v4_count++;
                    end
                end
                else
                begin
                    if (v6_count >= DEPTH)
                        r.status = lpr_pkg::STATUS_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < v6_count && !(m6 > v6_mask[pos]))
                            pos++;
                        for (int j = v6_count; j > pos; j--)
                        begin
                            v6_addr[j] = v6_addr[j-1];
                            v6_mask[j] = v6_mask[j-1];
                            v6_port[j] = v6_port[j-1];
                        end
                        v6_addr[pos] = a6;
                        v6_mask[pos] = m6;
                        v6_port[pos] = b.port;
                        v6_count++;
                    end
                end
            end
            lpr_pkg::KIND_LOOKUP:
            begin
                if (!b.v6)
                begin
                    for (int i = 0; i < v4_count; i++)
                        if (!r.found && prefix_hit({v4_addr[i], 96'd0}, {v4_mask[i], 96'd0},
                                                   {a4, 96'd0}, 4))
                        begin
                            r.found = 1'b1;
                            r.idx = v4_port[i];
                        end
                end
                else
                begin
                    for (int i = 0; i < v6_count; i++)
                        if (!r.found && prefix_hit(v6_addr[i], v6_mask[i], a6, 16))
                        begin
                            r.found = 1'b1;
                            r.idx = v6_port[i];
                        end
                end
            end
            lpr_pkg::KIND_CLEAR:
            begin
                v4_count = 0;
                v6_count = 0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // offer one beat, hold it until accepted, record the expected result
    task automatic send_beat(route_beat_t b, bit typed, route_res_t typed_res);
        route_res_t r;
        in_valid = 1'b1;
        kind = b.kind;
        family_v6 = b.v6;
        addr_hi = b.ahi;
        addr_lo = b.alo;
        mask_hi = b.mhi;
        mask_lo = b.mlo;
        port_index = b.port;
        route_flags = b.flags;
        do
            @(posedge clk);
        while (!in_ready);
        r = route_table_step(b);
        pending_results.push_back(typed ? typed_res : r);
        beats_sent++;
        @(negedge clk);
        // random gaps, none in the quiet stretch
        if ((beats_sent < 150 || beats_sent > 260) && $urandom_range(99) < 35)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    function automatic logic [127:0] prefix_mask(int len);
        return ~128'd0 << (128 - len);
    endfunction

    // random beat: mostly good inserts and lookups aimed at stored prefixes
    function automatic route_beat_t random_beat(int sel);
        route_beat_t  b;
        logic [127:0] m;
        logic [127:0] d;
        b.v6 = 1'($urandom_range(1));
        b.ahi = {$urandom, $urandom};
        b.alo = {$urandom, $urandom};
        b.mhi = {$urandom, $urandom};
        b.mlo = {$urandom, $urandom};
        b.port = 16'($urandom);
        b.flags = FLAGS_OK | ($urandom & ~(lpr_pkg::FLAG_CLONED | lpr_pkg::FLAG_SCOPED));
        if (sel < 40)
        begin
            b.kind = lpr_pkg::KIND_INSERT;
            if ($urandom_range(9) != 0)
            begin
                m = prefix_mask(b.v6 ? $urandom_range(128) : $urandom_range(32));
                if (!b.v6)
                    m[95:0] = {$urandom, $urandom, $urandom};
                b.mhi = m[127:64];
                b.mlo = m[63:0];
                b.ahi = b.ahi & b.mhi;
                b.alo = b.alo & b.mlo;
            end
            if (!b.v6)
                b.ahi[31:0] = $urandom;
            known_dests.push_back({b.ahi, b.alo});
        end
        else if (sel < 85)
        begin
            b.kind = lpr_pkg::KIND_LOOKUP;
            if (known_dests.size() > 0 && $urandom_range(3) != 0)
            begin
                d = known_dests[$urandom_range(known_dests.size() - 1)];
                d = d ^ (128'd1 << $urandom_range(127)) & {128{$urandom_range(1) == 1}};
                b.ahi = d[127:64];
                b.alo = d[63:0];
            end
        end
        else if (sel < 95)
        begin
            b.kind = lpr_pkg::KIND_INSERT;
            b.flags = $urandom;
        end
        else if (sel < 98)
            b.kind = KIND_UNUSED;
        else
            b.kind = lpr_pkg::KIND_CLEAR;
        return b;
    endfunction

    // result side: random back-pressure, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        held_off = 1'b0;
        forever
        begin
            @(negedge clk);
            if (beats_seen == 40 && !held_off)
            begin
                held_off = 1'b1;
                out_ready = 1'b0;
                repeat (400) @(negedge clk);
            end
            out_ready = (beats_seen >= 150 && beats_seen <= 260) ||
                        ($urandom_range(99) >= 35);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        route_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat found=%0b match_index=%0d status=%0d",
                         $time, found, match_index, status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (found !== e.found)
                begin
                    $display("%0t: found expected %0b actual %0b", $time, e.found, found);
                    errors++;
                end
                if (match_index !== e.idx)
                begin
                    $display("%0t: match_index expected %0d actual %0d",
                             $time, e.idx, match_index);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                    errors++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    // stimulus
    initial
    begin
        route_beat_t b;
        route_res_t  none;
        in_valid = 1'b0;
        kind = lpr_pkg::KIND_INSERT;
        family_v6 = 1'b0;
        addr_hi = '0;
        addr_lo = '0;
        mask_hi = '0;
        mask_lo = '0;
        port_index = '0;
        route_flags = '0;
        errors = 0;
        beats_sent = 0;
        beats_seen = 0;
        v4_count = 0;
        v6_count = 0;
        none = '{1'b0, 16'd0, lpr_pkg::STATUS_DONE};
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows: kind, v6, addr hi/lo, mask hi/lo, port, flags, typed, result
        stim_rows = '{
            '{'{lpr_pkg::KIND_LOOKUP, 1'b0, 64'hC0A8_0101_0000_0000, 0, 0, 0, 0, 0}, 1, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b1, '1, '1, 0, 0, 0, 0}, 1, none},
            '{'{lpr_pkg::KIND_INSERT, 1'b0, 0, 0, 0, 0, 1, lpr_pkg::FLAG_STATIC}, 1,
              '{1'b0, 16'd0, lpr_pkg::STATUS_FILTERED}},
            '{'{lpr_pkg::KIND_INSERT, 1'b0, 0, 0, 0, 0, 2, lpr_pkg::FLAG_UP}, 1,
              '{1'b0, 16'd0, lpr_pkg::STATUS_FILTERED}},
            '{'{lpr_pkg::KIND_INSERT, 1'b1, 0, 0, 0, 0, 3, FLAGS_OK | lpr_pkg::FLAG_CLONED}, 1,
              '{1'b0, 16'd0, lpr_pkg::STATUS_FILTERED}},
            '{'{lpr_pkg::KIND_INSERT, 1'b1, 0, 0, 0, 0, 4, FLAGS_OK | lpr_pkg::FLAG_SCOPED}, 1,
              '{1'b0, 16'd0, lpr_pkg::STATUS_FILTERED}},
            // default route then more specific ones
            '{'{lpr_pkg::KIND_INSERT, 1'b0, '1, '1, 0, '1, 16'hFFFF,
                '1 & ~(lpr_pkg::FLAG_CLONED | lpr_pkg::FLAG_SCOPED)}, 1, none},
            '{'{lpr_pkg::KIND_INSERT, 1'b0, 64'h0A00_0000_FFFF_FFFF, 0,
                64'hFF00_0000_0000_0000, 0, 16'd10, FLAGS_OK}, 1, none},
            '{'{lpr_pkg::KIND_INSERT, 1'b0, 64'h0A01_0200_0000_0000, 0,
                64'hFFFF_FF00_0000_0000, 0, 16'd24, FLAGS_OK}, 1, none},
            '{'{lpr_pkg::KIND_INSERT, 1'b0, 64'h0A01_0200_0000_0000, 0,
                64'hFFFF_FF00_0000_0000, 0, 16'd25, FLAGS_OK}, 1, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b0, 64'h0A01_0203_0000_0000, 0, 0, 0, 0, 0}, 0, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b0, 64'h0A09_0203_1234_5678, '1, 0, 0, 0, 0}, 0, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b0, 64'hC0A8_0001_0000_0000, 0, 0, 0, 0, 0}, 0, none},
            // non-contiguous mask
            '{'{lpr_pkg::KIND_INSERT, 1'b0, 64'h00FF_0000_0000_0000, 0,
                64'hF0FF_0000_0000_0000, 0, 16'd77, FLAGS_OK}, 1, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b0, 64'h0FFF_0000_0000_0000, 0, 0, 0, 0, 0}, 0, none},
            '{'{lpr_pkg::KIND_INSERT, 1'b1, 64'h2001_0DB8_0000_0000, 0,
                64'hFFFF_FFFF_0000_0000, 0, 16'd32, FLAGS_OK}, 1, none},
            '{'{lpr_pkg::KIND_INSERT, 1'b1, '1, '1, '1, '1, 16'd128, FLAGS_OK}, 1, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b1, 64'h2001_0DB8_AAAA_0000, 64'd5, 0, 0, 0, 0}, 0, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b1, '1, '1, 0, 0, 0, 0}, 0, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0, 0}, 0, none},
            '{'{KIND_UNUSED, 1'b1, '1, '1, '1, '1, '1, '1}, 1, none},
            '{'{lpr_pkg::KIND_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0}, 1, none},
            '{'{lpr_pkg::KIND_LOOKUP, 1'b0, 64'h0A01_0203_0000_0000, 0, 0, 0, 0, 0}, 1, none}
        };
        foreach (stim_rows[i])
            send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].res);

        // random traffic with a full-table phase in the middle
        for (int n = 0; n < 300; n++)
        begin
            if (n == 200)
            begin
                b = random_beat(99);
                send_beat(b, 0, none);
                for (int k = 0; k < 2 * DEPTH + 6; k++)
                begin
                    b = random_beat(0);
                    b.flags = FLAGS_OK;
                    b.v6 = (k >= DEPTH + 3);
                    send_beat(b, 0, none);
                end
            end
            b = random_beat($urandom_range(99));
            send_beat(b, 0, none);
        end
        in_valid = 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
